// File: hdl/arrt_pkg.sv
`timescale 1ns / 1ps
// arrt_pkg: shared types and constants for the authorization response relay table
// no dependencies; imported by auth_response_relay_table_unit and tb_top

package arrt_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_RESEND_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_SYSTEM_CHANNEL  = 2'd1;
   localparam logic [1:0] CSR_OWN_ADDRESS     = 2'd2;

   localparam logic [15:0] RESET_INTERVAL = 16'd5;
   localparam logic [7:0]  RESET_CHANNEL  = 8'd11;
   localparam logic [15:0] RESET_ADDRESS  = 16'd0;

   // item kinds
   localparam logic MODE_STORE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   typedef enum logic [2:0] {
      STAT_STORED  = 3'd0,
      STAT_BAD_LEN = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_SENT    = 3'd3,
      STAT_NONE    = 3'd4
   } arrt_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_WRITE
   } arrt_state_type;

   typedef struct packed {
      logic [63:0] mac;
      logic        access;
      logic [15:0] address;
      logic [63:0] param_low;
      logic [63:0] param_high;
   } arrt_entry_type;

endpackage

// File: hdl/auth_response_relay_table_unit.sv
`timescale 1ns / 1ps
// auth_response_relay_table_unit: relay table top level, built on arrt_pkg
// Steps: a rejected store or a tick that fails the relay or interval check gives its
// result from the check state; otherwise the item goes on to a one-entry scan over the
// table memory with one compare unit, and a stored entry takes a write state after it.
// A new item is taken only once the previous item is done; busy is high meanwhile.
// One-cycle result strobes, receiver cannot stall; reset clears valid bits, send time, regs.

module auth_response_relay_table_unit
   import arrt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 8,
   parameter int RECORD_BYTES  = 27
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_frame_length,
   input  logic [63:0] req_entry_mac,
   input  logic        req_entry_access,
   input  logic [15:0] req_entry_address,
   input  logic [63:0] req_entry_param_low,
   input  logic [63:0] req_entry_param_high,
   input  logic [31:0] req_current_time,
   input  logic        req_relay_enabled,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_sent_mac,
   output logic        rsp_sent_access,
   output logic [15:0] rsp_sent_address,
   output logic [63:0] rsp_sent_param_low,
   output logic [63:0] rsp_sent_param_high,
   output logic [7:0]  rsp_frame_channel,
   output logic [15:0] rsp_frame_source,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   arrt_state_type state_ff, state_in;

   // configuration
   logic [15:0] interval_ff;
   logic [7:0]  channel_ff;
   logic [15:0] source_ff;

   // latched item
   logic           mode_ff;
   logic [7:0]     length_ff;
   arrt_entry_type item_ff;
   logic [31:0]    time_ff;
   logic           relay_ff;

   logic [31:0] last_send_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   arrt_entry_type entry_mem [TABLE_ENTRIES];

   // scan loop
   logic [IDX_W-1:0] scan_ff;
   logic             issue_done_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_live_ff;
   arrt_entry_type   rd_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic [IDX_W-1:0] slot_ff, slot_in;

   // result registers
   logic            rsp_valid_ff;
   arrt_status_type rsp_status_ff;
   arrt_entry_type  rsp_entry_ff;
   logic [7:0]      rsp_channel_ff;
   logic [15:0]     rsp_source_ff;

   // control
   logic            accept;
   logic            issue;
   logic            hit;
   logic            last;
   logic            check_pass;
   logic            elapsed;
   logic [31:0]     since_send;
   logic            finish;
   logic            do_send;
   logic            upd_time;
   arrt_status_type fin_status;

   assign since_send = time_ff - last_send_ff;
   assign elapsed    = since_send >= {16'd0, interval_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = check_pass ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = (mode_ff == MODE_TICK) ? ST_IDLE : ST_WRITE;
            end else if (last) begin
               state_in = (mode_ff == MODE_STORE && free_found_ff) ? ST_WRITE : ST_IDLE;
            end
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      accept     = (state_ff == ST_IDLE) && start;
      issue      = (state_ff == ST_SCAN) && !issue_done_ff;
      hit        = (state_ff == ST_SCAN) && rd_live_ff && valid_ff[rd_idx_ff]
                   && ((mode_ff == MODE_TICK) || (rd_ff.mac == item_ff.mac));
      last       = (state_ff == ST_SCAN) && rd_live_ff && (rd_idx_ff == LAST_IDX);
      check_pass = (mode_ff == MODE_TICK) ? (relay_ff && elapsed)
                                          : (length_ff == 8'(RECORD_BYTES));
      finish     = 1'b0;
      do_send    = 1'b0;
      upd_time   = 1'b0;
      fin_status = STAT_NONE;
      slot_in    = slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_CHECK: begin
            upd_time = check_pass && (mode_ff == MODE_TICK);
            if (!check_pass) begin
               finish     = 1'b1;
               fin_status = (mode_ff == MODE_TICK) ? STAT_NONE : STAT_BAD_LEN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               slot_in = rd_idx_ff;
               if (mode_ff == MODE_TICK) begin
                  finish     = 1'b1;
                  do_send    = 1'b1;
                  fin_status = STAT_SENT;
               end
            end else if (last) begin
               slot_in = free_idx_ff;
               if (mode_ff == MODE_TICK) begin
                  finish     = 1'b1;
                  fin_status = STAT_NONE;
               end else if (!free_found_ff) begin
                  finish     = 1'b1;
                  fin_status = STAT_FULL;
               end
            end
         end
         ST_WRITE: begin
            finish     = 1'b1;
            fin_status = STAT_STORED;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         interval_ff   <= RESET_INTERVAL;
         channel_ff    <= RESET_CHANNEL;
         source_ff     <= RESET_ADDRESS;
         last_send_ff  <= 32'd0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         issue_done_ff <= 1'b0;
         rd_live_ff    <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= finish;
         if (csr_write) begin
            unique case (csr_index)
               CSR_RESEND_INTERVAL: interval_ff <= csr_wdata;
               CSR_SYSTEM_CHANNEL:  channel_ff  <= csr_wdata[7:0];
               CSR_OWN_ADDRESS:     source_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (upd_time) last_send_ff <= time_ff;
         if (state_ff == ST_CHECK) begin
            issue_done_ff <= 1'b0;
            rd_live_ff    <= 1'b0;
            free_found_ff <= 1'b0;
         end else begin
            rd_live_ff <= issue;
            if (issue && scan_ff == LAST_IDX) issue_done_ff <= 1'b1;
            if (issue && !valid_ff[scan_ff] && !free_found_ff) free_found_ff <= 1'b1;
         end
         if (state_ff == ST_WRITE) valid_ff[slot_ff] <= 1'b1;
         if (do_send) valid_ff[rd_idx_ff] <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff             <= req_mode;
         length_ff           <= req_frame_length;
         item_ff.mac         <= req_entry_mac;
         item_ff.access      <= req_entry_access;
         item_ff.address     <= req_entry_address;
         item_ff.param_low   <= req_entry_param_low;
         item_ff.param_high  <= req_entry_param_high;
         time_ff             <= req_current_time;
         relay_ff            <= req_relay_enabled;
      end
      if (state_ff == ST_CHECK) begin
         scan_ff <= '0;
      end else if (issue && scan_ff != LAST_IDX) begin
         scan_ff <= scan_ff + 1'b1;
      end
      if (issue) rd_idx_ff <= scan_ff;
      if (issue && !valid_ff[scan_ff] && !free_found_ff) free_idx_ff <= scan_ff;
      slot_ff <= slot_in;
      if (finish) begin
         rsp_status_ff  <= fin_status;
         rsp_entry_ff   <= do_send ? rd_ff : '0;
         rsp_channel_ff <= do_send ? channel_ff : 8'd0;
         rsp_source_ff  <= do_send ? source_ff : 16'd0;
      end
   end

   // entry memory, one registered read port on the scan index
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) entry_mem[slot_ff] <= item_ff;
      if (issue) rd_ff <= entry_mem[scan_ff];
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_sent_mac        = rsp_entry_ff.mac;
   assign rsp_sent_access     = rsp_entry_ff.access;
   assign rsp_sent_address    = rsp_entry_ff.address;
   assign rsp_sent_param_low  = rsp_entry_ff.param_low;
   assign rsp_sent_param_high = rsp_entry_ff.param_high;
   assign rsp_frame_channel   = rsp_channel_ff;
   assign rsp_frame_source    = rsp_source_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) != ST_IDLE)
      else $error("result strobe without an item in progress");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |=> valid_ff[$past(slot_ff)])
      else $error("stored entry not marked valid");

   a_send_frees_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_SENT
      |-> $countones(valid_ff) + 1 == $countones($past(valid_ff)))
      else $error("sent response did not free exactly one entry");

   a_store_keeps_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_SENT && rsp_status != STAT_STORED
      |-> valid_ff == $past(valid_ff))
      else $error("valid bits changed on an item that stored and sent nothing");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for auth_response_relay_table_unit (store, overwrite,
// table full, timed relay with wrapped time); expected beats come from a table model
// kept in the bench. depends on arrt_pkg and the unit itself

module tb_top
   import arrt_pkg::*;
();

   localparam int TABLE_SIZE = 8;
   localparam int RECORD_LEN = 27;
   localparam logic [7:0] GOOD_LEN = 8'(RECORD_LEN);
   localparam int QUIET_TAIL = 60;
   localparam int PHASE_OPS  = 67;
   // index past the last register, writes there must be dropped
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic        is_csr;
      logic [1:0]  csr_idx;
      logic [15:0] csr_val;
      logic        mode;
      logic [7:0]  len;
      logic [63:0] mac;
      logic        access;
      logic [15:0] address;
      logic [63:0] param_low;
      logic [63:0] param_high;
      logic [31:0] now;
      logic        relay_on;
   } table_op_type;

   typedef struct {
      logic [2:0]  status;
      logic [63:0] mac;
      logic        access;
      logic [15:0] address;
      logic [63:0] param_low;
      logic [63:0] param_high;
      logic [7:0]  channel;
      logic [15:0] source;
   } relay_resp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = MODE_STORE;
   logic [7:0]  req_frame_length = '0;
   logic [63:0] req_entry_mac = '0;
   logic        req_entry_access = 1'b0;
   logic [15:0] req_entry_address = '0;
   logic [63:0] req_entry_param_low = '0;
   logic [63:0] req_entry_param_high = '0;
   logic [31:0] req_current_time = '0;
   logic        req_relay_enabled = 1'b0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_sent_mac;
   logic        rsp_sent_access;
   logic [15:0] rsp_sent_address;
   logic [63:0] rsp_sent_param_low;
   logic [63:0] rsp_sent_param_high;
   logic [7:0]  rsp_frame_channel;
   logic [15:0] rsp_frame_source;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   table_op_type   pending_ops[$];
   relay_resp_type expected_responses[$];
   table_op_type   on_port;
   int             items_sent = 0;
   int             results_seen = 0;
   int             failures = 0;
   int             idle_left = 0;

   // bench copy of the relay table and its registers
   logic [15:0] cfg_interval;
   logic [7:0]  cfg_channel;
   logic [15:0] cfg_source;
   logic        tbl_valid [TABLE_SIZE];
   logic [63:0] tbl_mac [TABLE_SIZE];
   logic        tbl_access [TABLE_SIZE];
   logic [15:0] tbl_address [TABLE_SIZE];
   logic [63:0] tbl_param_low [TABLE_SIZE];
   logic [63:0] tbl_param_high [TABLE_SIZE];
   logic [31:0] tbl_last_send;

   auth_response_relay_table_unit #(
      .TABLE_ENTRIES(TABLE_SIZE),
      .RECORD_BYTES (RECORD_LEN)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_frame_length    (req_frame_length),
      .req_entry_mac       (req_entry_mac),
      .req_entry_access    (req_entry_access),
      .req_entry_address   (req_entry_address),
      .req_entry_param_low (req_entry_param_low),
      .req_entry_param_high(req_entry_param_high),
      .req_current_time    (req_current_time),
      .req_relay_enabled   (req_relay_enabled),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_sent_mac        (rsp_sent_mac),
      .rsp_sent_access     (rsp_sent_access),
      .rsp_sent_address    (rsp_sent_address),
      .rsp_sent_param_low  (rsp_sent_param_low),
      .rsp_sent_param_high (rsp_sent_param_high),
      .rsp_frame_channel   (rsp_frame_channel),
      .rsp_frame_source    (rsp_frame_source),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void push_csr(logic [1:0] idx, logic [15:0] val);
      table_op_type op;
      op = '{default: '0};
      op.is_csr  = 1'b1;
      op.csr_idx = idx;
      op.csr_val = val;
      pending_ops.push_back(op);
   endfunction

   // time and relay flag get noise, a store must ignore them
   function automatic void push_store(logic [7:0] len, logic [63:0] mac, logic access,
                                      logic [15:0] address, logic [63:0] plo,
                                      logic [63:0] phi);
      table_op_type op;
      op.is_csr     = 1'b0;
      op.csr_idx    = '0;
      op.csr_val    = '0;
      op.mode       = MODE_STORE;
      op.len        = len;
      op.mac        = mac;
      op.access     = access;
      op.address    = address;
      op.param_low  = plo;
      op.param_high = phi;
      op.now        = $urandom;
      op.relay_on   = 1'($urandom_range(0, 1));
      pending_ops.push_back(op);
   endfunction

   // entry fields get noise, a tick must ignore them
   function automatic void push_tick(logic [31:0] now, logic relay_on);
      table_op_type op;
      op.is_csr     = 1'b0;
      op.csr_idx    = '0;
      op.csr_val    = '0;
      op.mode       = MODE_TICK;
      op.len        = 8'($urandom_range(0, 255));
      op.mac        = rand64();
      op.access     = 1'($urandom_range(0, 1));
      op.address    = 16'($urandom_range(0, 65535));
      op.param_low  = rand64();
      op.param_high = rand64();
      op.now        = now;
      op.relay_on   = relay_on;
      pending_ops.push_back(op);
   endfunction

   function automatic void apply_register_write(logic [1:0] idx, logic [15:0] val);
      case (idx)
         CSR_RESEND_INTERVAL: cfg_interval = val;
         CSR_SYSTEM_CHANNEL:  cfg_channel = val[7:0];
         CSR_OWN_ADDRESS:     cfg_source = val;
         default: ;
      endcase
   endfunction

   function automatic relay_resp_type table_outcome(table_op_type op);
      relay_resp_type r;
      int             slot;
      r = '{default: '0};
      slot = -1;
      if (op.mode == MODE_STORE) begin
         if (op.len != GOOD_LEN) begin
            r.status = STAT_BAD_LEN;
         end else begin
            // same mac first, else lowest free entry
            for (int i = 0; i < TABLE_SIZE; i++)
               if (slot < 0 && tbl_valid[i] && tbl_mac[i] == op.mac) slot = i;
            for (int i = 0; i < TABLE_SIZE; i++)
               if (slot < 0 && !tbl_valid[i]) slot = i;
            if (slot < 0) begin
               r.status = STAT_FULL;
            end else begin
               tbl_valid[slot]      = 1'b1;
               tbl_mac[slot]        = op.mac;
               tbl_access[slot]     = op.access;
               tbl_address[slot]    = op.address;
               tbl_param_low[slot]  = op.param_low;
               tbl_param_high[slot] = op.param_high;
               r.status = STAT_STORED;
            end
         end
      end else begin
         r.status = STAT_NONE;
         // wrapped 32-bit difference; send time moves even with an empty table
         if (op.relay_on && (op.now - tbl_last_send) >= {16'd0, cfg_interval}) begin
            tbl_last_send = op.now;
            for (int i = 0; i < TABLE_SIZE; i++)
               if (slot < 0 && tbl_valid[i]) slot = i;
            if (slot >= 0) begin
               r.status     = STAT_SENT;
               r.mac        = tbl_mac[slot];
               r.access     = tbl_access[slot];
               r.address    = tbl_address[slot];
               r.param_low  = tbl_param_low[slot];
               r.param_high = tbl_param_high[slot];
               r.channel    = cfg_channel;
               r.source     = cfg_source;
               tbl_valid[slot] = 1'b0;
            end
         end
      end
      return r;
   endfunction

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         failures++;
      end
   endtask

   // driver: one beat per start/busy handshake, register writes only when idle
   always @(posedge clock) begin : drive_ops
      logic drive_start;
      logic drive_csr;
      if (reset) begin
         start     <= 1'b0;
         csr_write <= 1'b0;
         cfg_interval  = RESET_INTERVAL;
         cfg_channel   = RESET_CHANNEL;
         cfg_source    = RESET_ADDRESS;
         tbl_last_send = '0;
         for (int i = 0; i < TABLE_SIZE; i++) tbl_valid[i] = 1'b0;
      end else begin
         drive_start = start;
         drive_csr   = 1'b0;
         if (csr_write) apply_register_write(csr_index, csr_wdata);
         if (start && !busy) begin
            expected_responses.push_back(table_outcome(on_port));
            void'(pending_ops.pop_front());
            items_sent <= items_sent + 1;
            drive_start = 1'b0;
            if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 2) == 0)
               idle_left = $urandom_range(1, 10);
         end
         if (!drive_start && pending_ops.size() != 0) begin
            if (idle_left != 0) begin
               idle_left--;
            end else if (pending_ops[0].is_csr) begin
               if (!start && !busy && items_sent == results_seen) begin
                  drive_csr = 1'b1;
                  csr_index <= pending_ops[0].csr_idx;
                  csr_wdata <= pending_ops[0].csr_val;
                  void'(pending_ops.pop_front());
               end
            end else begin
               on_port = pending_ops[0];
               drive_start = 1'b1;
               req_mode             <= on_port.mode;
               req_frame_length     <= on_port.len;
               req_entry_mac        <= on_port.mac;
               req_entry_access     <= on_port.access;
               req_entry_address    <= on_port.address;
               req_entry_param_low  <= on_port.param_low;
               req_entry_param_high <= on_port.param_high;
               req_current_time     <= on_port.now;
               req_relay_enabled    <= on_port.relay_on;
            end
         end
         start     <= drive_start;
         csr_write <= drive_csr;
      end
   end

   always @(posedge clock) begin : check_responses
      relay_resp_type want;
      if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            $display("%0t: response beat, expected none, actual status %0d",
                     $time, rsp_status);
            failures++;
         end else begin
            want = expected_responses.pop_front();
            results_seen <= results_seen + 1;
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("sent_mac", want.mac, rsp_sent_mac);
            check_field("sent_access", 64'(want.access), 64'(rsp_sent_access));
            check_field("sent_address", 64'(want.address), 64'(rsp_sent_address));
            check_field("sent_param_low", want.param_low, rsp_sent_param_low);
            check_field("sent_param_high", want.param_high, rsp_sent_param_high);
            check_field("frame_channel", 64'(want.channel), 64'(rsp_frame_channel));
            check_field("frame_source", 64'(want.source), 64'(rsp_frame_source));
         end
      end
   end

   initial begin : run_ops
      logic [63:0] mac_pool [12];
      logic [15:0] phase_interval [6];
      logic [15:0] phase_channel [6];
      logic [15:0] phase_source [6];
      logic [31:0] tick_now;
      int unsigned ival;
      int          store_pct;
      int          n;

      // disabled, too early, then empty table after the interval
      push_tick(32'hffff_ffff, 1'b0);
      push_tick(32'd3, 1'b1);
      push_tick(32'd5, 1'b1);
      push_store(8'd0, rand64(), 1'b1, 16'h0001, rand64(), rand64());
      push_store(8'd255, rand64(), 1'b0, 16'h0002, rand64(), rand64());
      push_store(8'(RECORD_LEN - 1), rand64(), 1'b1, 16'h0003, rand64(), rand64());
      push_store(8'(RECORD_LEN + 1), rand64(), 1'b1, 16'h0004, rand64(), rand64());
      push_store(GOOD_LEN, '1, 1'b1, 16'hffff, '1, '1);
      push_store(GOOD_LEN, '0, 1'b0, 16'h0000, '0, '0);
      // same mac again overwrites in place
      push_store(GOOD_LEN, '1, 1'b0, 16'h1234, rand64(), rand64());
      for (n = 0; n < TABLE_SIZE - 2; n++)
         push_store(GOOD_LEN, rand64(), 1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 65535)), rand64(), rand64());
      push_store(GOOD_LEN, rand64(), 1'b1, 16'h5555, rand64(), rand64());
      // full table still takes an update of a known mac
      push_store(GOOD_LEN, '0, 1'b1, 16'haaaa, rand64(), rand64());
      push_tick(32'd7, 1'b1);
      push_tick(32'd10, 1'b1);
      push_store(GOOD_LEN, rand64(), 1'b1, 16'h0f0f, rand64(), rand64());
      // wrap of the time counter
      push_tick(32'hffff_ffff, 1'b1);
      push_tick(32'd2, 1'b1);
      push_tick(32'd4, 1'b1);
      push_tick(32'd9, 1'b0);

      for (n = 0; n < 12; n++) mac_pool[n] = rand64();
      phase_interval = '{16'd0, 16'hffff, 16'd1, 16'd0, 16'd5, 16'd0};
      phase_interval[3] = 16'($urandom_range(2, 40));
      phase_interval[5] = 16'($urandom_range(100, 3000));
      phase_channel = '{16'h00ff, 16'h0000, 16'h0000, 16'h00ff, 16'h0000, 16'h0000};
      phase_channel[2] = 16'($urandom_range(0, 65535));
      phase_channel[4] = 16'($urandom_range(0, 65535));
      phase_source = '{16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0000};
      phase_source[2] = 16'($urandom_range(0, 65535));
      phase_source[3] = 16'($urandom_range(0, 65535));
      phase_source[5] = 16'($urandom_range(0, 65535));

      tick_now = 32'd100;
      for (int p = 0; p < 6; p++) begin
         if (p == 0) push_csr(CSR_SPARE, 16'hffff);
         push_csr(CSR_RESEND_INTERVAL, phase_interval[p]);
         push_csr(CSR_SYSTEM_CHANNEL, phase_channel[p]);
         push_csr(CSR_OWN_ADDRESS, phase_source[p]);
         ival = 32'(phase_interval[p]);
         store_pct = (p % 2 == 0) ? 65 : 45;
         for (int k = 0; k < PHASE_OPS; k++) begin
            if ($urandom_range(0, 99) < store_pct) begin
               push_store(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : GOOD_LEN,
                          ($urandom_range(0, 3) == 0) ? rand64() : mac_pool[$urandom_range(0, 11)],
                          1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                          rand64(), rand64());
            end else begin
               if ($urandom_range(0, 9) == 0)
                  tick_now = $urandom;
               else
                  tick_now += $urandom_range(0, ival + ival / 2 + 2);
               push_tick(tick_now, $urandom_range(0, 4) != 0);
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || start) @(posedge clock);
      for (n = 0; n < 200 && expected_responses.size() != 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_responses.size() != 0)
         $display("%0t: response beats missing, expected 0 pending, actual %0d pending",
                  $time, expected_responses.size());
      if (failures == 0 && expected_responses.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

// File: files.f
hdl/arrt_pkg.sv
hdl/auth_response_relay_table_unit.sv
dv/tb_top.sv
